// ===== rtl/prioritized_interrupt_dispatcher_defines.svh =====
// assertion macros shared by the dispatcher modules
// no dependencies
`ifndef PRIORITIZED_INTERRUPT_DISPATCHER_DEFINES_SVH
`define PRIORITIZED_INTERRUPT_DISPATCHER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PID_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every clock edge, reset included
`define PID_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/pid_pkg.sv =====
// shared types and constants for the interrupt dispatcher
// no dependencies
`timescale 1ns / 1ps
package pid_pkg;

  localparam int TimeW = 63;
  localparam int AddrW = 32;

  typedef enum logic [3:0] {
    CMD_CHECK     = 4'd0,
    CMD_KEYPRESS  = 4'd1,
    CMD_RETURN    = 4'd2,
    CMD_ARM_TICK  = 4'd3,
    CMD_DIS_TICK  = 4'd4,
    CMD_ARM_PORT  = 4'd5,
    CMD_DIS_PORT  = 4'd6,
    CMD_ARM_ANY   = 4'd7,
    CMD_DIS_ANY   = 4'd8,
    CMD_ARM_KEY   = 4'd9,
    CMD_DIS_KEY   = 4'd10,
    CMD_PAUSE     = 4'd11,
    CMD_RESUMEQ   = 4'd12,
    CMD_RXLEVEL   = 4'd13,
    CMD_CLEAR     = 4'd14,
    CMD_NOP       = 4'd15
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_ANY  = 3'd1,
    KIND_KEY  = 3'd2,
    KIND_TICK = 3'd3,
    KIND_PORT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_NOINT  = 2'd1,
    ERR_BADIDX = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_PORT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       scan_tick;
    logic       scan_port;
    logic       finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic       is_check;
    logic       check_go;
    logic       quick_hit;
    logic       hit;
    logic       tick_last;
    logic       port_last;
  } ctl_stat_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

endpackage

// ===== rtl/pid_if.sv =====
// valid/ready channel carrying one payload beat
// depends on nothing
`timescale 1ns / 1ps
interface pid_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/prioritized_interrupt_dispatcher.sv =====
// channel  | dir | payload
// in_ch    | in  | command, now_time, key_available, program_running, index, value,
//          |     | key_code, address
// out_ch   | out | fired, source_kind, source_index, address_out, flag_out, in_interrupt, error
// one beat at a time: load, execute, optional scan, deliver
// non-check commands and key dispatch skip the scan and go from execute to deliver
// a check that reaches the timer/port scan visits one entry per cycle:
// tick entries first, then port entries, stopping at the first hit, in a sequential table scan
// synchronous reset clears every source; a stalled output holds the input side
// top level of the interrupt dispatcher; depends on pid_pkg, pid_if, pid_ctrl, pid_dp
`timescale 1ns / 1ps
module prioritized_interrupt_dispatcher
  import pid_pkg::*;
#(
  parameter int NUM_TICKS = 4,
  parameter int NUM_PORTS = 10
) (
  input  logic clk,
  input  logic rst,
  pid_if.sink   in_ch,
  pid_if.source out_ch
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  pid_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  pid_dp #(.NUM_TICKS(NUM_TICKS), .NUM_PORTS(NUM_PORTS)) u_dp (
    .clk(clk), .rst(rst),
    .command(in_ch.data.command),
    .now_time(in_ch.data.now_time),
    .key_available(in_ch.data.key_available),
    .program_running(in_ch.data.program_running),
    .index(in_ch.data.index),
    .value(in_ch.data.value),
    .key_code(in_ch.data.key_code),
    .address(in_ch.data.address),
    .cmd(cmd), .stat(stat),
    .fired(out_ch.data.fired),
    .source_kind(out_ch.data.source_kind),
    .source_index(out_ch.data.source_index),
    .address_out(out_ch.data.address_out),
    .flag_out(out_ch.data.flag_out),
    .in_interrupt(out_ch.data.in_interrupt),
    .error(out_ch.data.error)
  );

endmodule

// ===== rtl/pid_ctrl.sv =====
// sequencer for the interrupt dispatcher
// depends on pid_pkg and prioritized_interrupt_dispatcher_defines.svh
`timescale 1ns / 1ps
`include "prioritized_interrupt_dispatcher_defines.svh"
module pid_ctrl
  import pid_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_check && stat.check_go && !stat.quick_hit) begin
          state_next = ST_TICK;
        end else begin
          cmd.exec = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_TICK: begin
        cmd.scan_tick = 1'b1;
        if (stat.hit) state_next = ST_DONE;
        else if (stat.tick_last) state_next = ST_PORT;
      end
      ST_PORT: begin
        cmd.scan_port = 1'b1;
        if (stat.hit || stat.port_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `PID_ASSERT(a_ready_idle, clk, rst, in_ready |-> state == ST_IDLE, "ready outside idle")
  `PID_ASSERT(a_done_after, clk, rst, $rose(out_valid) |-> $past(state) != ST_IDLE, "beat without work")
  `PID_ASSERT(a_one_op, clk, rst, $countones({cmd.load, cmd.exec, cmd.scan_tick, cmd.scan_port, cmd.finish}) <= 1, "overlapping commands")

endmodule

// ===== rtl/pid_dp.sv =====
// state registers, source tables and scan datapath
// depends on pid_pkg and the assertion macros of prioritized_interrupt_dispatcher_defines.svh
`timescale 1ns / 1ps
module pid_dp
  import pid_pkg::*;
#(
  parameter int NUM_TICKS = 4,
  parameter int NUM_PORTS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [3:0]       command,
  input  logic [TimeW-1:0] now_time,
  input  logic             key_available,
  input  logic             program_running,
  input  logic [3:0]       index,
  input  logic [TimeW-1:0] value,
  input  logic [7:0]       key_code,
  input  logic [AddrW-1:0] address,
  input  ctl_cmd_t         cmd,
  output ctl_stat_t        stat,
  output logic             fired,
  output logic [2:0]       source_kind,
  output logic [3:0]       source_index,
  output logic [AddrW-1:0] address_out,
  output logic             flag_out,
  output logic             in_interrupt,
  output logic [1:0]       error
);

  localparam int TW = (NUM_TICKS > 1) ? $clog2(NUM_TICKS) : 1;
  localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // latched request
  cmd_t             r_cmd;
  logic [TimeW-1:0] r_now, r_val;
  logic             r_kav, r_run;
  logic [3:0]       r_idx;
  logic [7:0]       r_kc;
  logic [AddrW-1:0] r_addr;

  logic             active_flag, pause_flag, anykey_armed, key_armed, key_pending;
  logic [AddrW-1:0] resume_address, anykey_handler, key_handler;
  logic [7:0]       key_match_code;
  logic [NUM_TICKS-1:0] tick_armed;
  logic [TimeW-1:0] tick_due [NUM_TICKS];
  logic [TimeW-1:0] tick_period [NUM_TICKS];
  logic [AddrW-1:0] tick_handler [NUM_TICKS];
  logic [NUM_PORTS-1:0] port_armed;
  logic [TimeW-1:0] port_threshold [NUM_PORTS];
  logic [AddrW-1:0] port_handler [NUM_PORTS];
  logic [TimeW-1:0] port_level [NUM_PORTS];

  logic [TW-1:0] tptr;
  logic [PW-1:0] pptr;

  logic tick_ok, port_ok;
  logic [TW-1:0] ti;
  logic [PW-1:0] pi;
  logic [4:0] pidx1;
  logic tick_hit, port_hit;

  assign tick_ok = {1'b0, r_idx} < 5'(NUM_TICKS);
  assign port_ok = (r_idx != 4'd0) && ({1'b0, r_idx} <= 5'(NUM_PORTS));
  assign ti = r_idx[TW-1:0];
  assign pidx1 = {1'b0, r_idx} - 5'd1;
  assign pi = pidx1[PW-1:0];

  assign tick_hit = tick_armed[tptr] && (r_now >= tick_due[tptr]);
  assign port_hit = port_armed[pptr] && (port_level[pptr] >= port_threshold[pptr]);

  always_comb begin
    stat.is_check = (r_cmd == CMD_CHECK);
    stat.check_go = (anykey_armed || key_armed || |tick_armed || |port_armed)
                    && !active_flag && r_run;
    stat.quick_hit = (anykey_armed && r_kav) || (key_armed && key_pending);
    stat.hit = (cmd.scan_tick && tick_hit) || (cmd.scan_port && port_hit);
    stat.tick_last = ({1'b0, tptr} == (TW+1)'(NUM_TICKS - 1));
    stat.port_last = ({1'b0, pptr} == (PW+1)'(NUM_PORTS - 1));
  end

  assign in_interrupt = active_flag;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_cmd <= cmd_t'(command);
      r_now <= now_time;
      r_val <= value;
      r_kav <= key_available;
      r_run <= program_running;
      r_idx <= index;
      r_kc <= key_code;
      r_addr <= address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag <= 1'b0;
      pause_flag <= 1'b0;
      anykey_armed <= 1'b0;
      key_armed <= 1'b0;
      key_pending <= 1'b0;
      resume_address <= '0;
      anykey_handler <= '0;
      key_handler <= '0;
      key_match_code <= '0;
      tick_armed <= '0;
      port_armed <= '0;
      for (int i = 0; i < NUM_TICKS; i++) begin
        tick_due[i] <= '0;
        tick_period[i] <= '0;
        tick_handler[i] <= '0;
      end
      for (int i = 0; i < NUM_PORTS; i++) begin
        port_threshold[i] <= '0;
        port_handler[i] <= '0;
        port_level[i] <= '0;
      end
      tptr <= '0;
      pptr <= '0;
      fired <= 1'b0;
      source_kind <= KIND_NONE;
      source_index <= '0;
      address_out <= '0;
      flag_out <= 1'b0;
      error <= ERR_OK;
    end else begin
      if (cmd.load) begin
        fired <= 1'b0;
        source_kind <= KIND_NONE;
        source_index <= '0;
        address_out <= '0;
        flag_out <= 1'b0;
        error <= ERR_OK;
        tptr <= '0;
        pptr <= '0;
      end
      if (cmd.scan_tick) begin
        if (tick_hit) begin
          tick_due[tptr] <= sat_add(tick_due[tptr], tick_period[tptr]);
          fired <= 1'b1;
          source_kind <= KIND_TICK;
          source_index <= 4'(tptr);
          address_out <= tick_handler[tptr];
          active_flag <= 1'b1;
          resume_address <= r_addr;
        end else if (!stat.tick_last) begin
          tptr <= tptr + TW'(1);
        end
      end
      if (cmd.scan_port && port_hit) begin
        fired <= 1'b1;
        source_kind <= KIND_PORT;
        source_index <= 4'({1'b0, pptr} + (PW+1)'(1));
        address_out <= port_handler[pptr];
        active_flag <= 1'b1;
        resume_address <= r_addr;
      end else if (cmd.scan_port && !stat.port_last) begin
        pptr <= pptr + PW'(1);
      end
      if (cmd.exec) begin
        unique case (r_cmd)
          CMD_CHECK: begin
            if (stat.check_go) begin
              fired <= 1'b1;
              active_flag <= 1'b1;
              resume_address <= r_addr;
              if (anykey_armed && r_kav) begin
                source_kind <= KIND_ANY;
                address_out <= anykey_handler;
              end else begin
                key_pending <= 1'b0;
                source_kind <= KIND_KEY;
                address_out <= key_handler;
              end
            end
          end
          CMD_KEYPRESS: begin
            if (key_armed && r_kc == key_match_code) begin
              key_pending <= 1'b1;
              flag_out <= 1'b1;
            end
          end
          CMD_RETURN: begin
            if (!active_flag) error <= ERR_NOINT;
            else begin
              address_out <= resume_address;
              active_flag <= 1'b0;
            end
          end
          CMD_ARM_TICK: begin
            if (!tick_ok) error <= ERR_BADIDX;
            else begin
              tick_armed[ti] <= 1'b1;
              tick_due[ti] <= sat_add(r_now, r_val);
              tick_period[ti] <= r_val;
              tick_handler[ti] <= r_addr;
            end
          end
          CMD_DIS_TICK: begin
            if (!tick_ok) error <= ERR_BADIDX;
            else begin
              tick_armed[ti] <= 1'b0;
              tick_due[ti] <= '0;
              tick_period[ti] <= '0;
              tick_handler[ti] <= '0;
            end
          end
          CMD_ARM_PORT: begin
            if (!port_ok || port_armed[pi]) error <= ERR_BADIDX;
            else begin
              port_armed[pi] <= 1'b1;
              port_threshold[pi] <= r_val;
              port_handler[pi] <= r_addr;
            end
          end
          CMD_DIS_PORT: begin
            if (!port_ok) error <= ERR_BADIDX;
            else begin
              port_armed[pi] <= 1'b0;
              port_threshold[pi] <= '0;
              port_handler[pi] <= '0;
            end
          end
          CMD_ARM_ANY: begin
            anykey_armed <= 1'b1;
            anykey_handler <= r_addr;
          end
          CMD_DIS_ANY: begin
            anykey_armed <= 1'b0;
            anykey_handler <= '0;
          end
          CMD_ARM_KEY: begin
            key_armed <= 1'b1;
            key_match_code <= r_kc;
            key_handler <= r_addr;
          end
          CMD_DIS_KEY: begin
            key_armed <= 1'b0;
            key_handler <= '0;
          end
          CMD_PAUSE: begin
            active_flag <= 1'b1;
            pause_flag <= 1'b1;
            resume_address <= r_addr;
          end
          CMD_RESUMEQ: begin
            flag_out <= pause_flag;
            pause_flag <= 1'b0;
          end
          CMD_RXLEVEL: begin
            if (!port_ok) error <= ERR_BADIDX;
            else port_level[pi] <= r_val;
          end
          CMD_CLEAR: begin
            active_flag <= 1'b0;
            pause_flag <= 1'b0;
            anykey_armed <= 1'b0;
            key_armed <= 1'b0;
            key_pending <= 1'b0;
            resume_address <= '0;
            anykey_handler <= '0;
            key_handler <= '0;
            key_match_code <= '0;
            tick_armed <= '0;
            port_armed <= '0;
            for (int i = 0; i < NUM_TICKS; i++) begin
              tick_due[i] <= '0;
              tick_period[i] <= '0;
              tick_handler[i] <= '0;
            end
            for (int i = 0; i < NUM_PORTS; i++) begin
              port_threshold[i] <= '0;
              port_handler[i] <= '0;
            end
          end
          CMD_NOP: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  `PID_ASSERT(a_fire_active, clk, rst, $rose(fired) |-> active_flag, "fire without active flag")
  `PID_ASSERT(a_kind_fired, clk, rst, (source_kind != KIND_NONE) |-> fired, "kind without fire")
  `PID_ASSERT(a_scan_noact, clk, rst, (cmd.scan_tick || cmd.scan_port) && !stat.hit |=> !fired, "scan fired without hit")

endmodule

// ===== tb/pid_tb_pkg.sv =====
// beat layouts of the dispatcher command and response channels
// depends on pid_pkg
`timescale 1ns / 1ps
package pid_tb_pkg;
  import pid_pkg::*;

  typedef struct packed {
    cmd_t              command;
    logic [TimeW-1:0]  now_time;
    logic              key_available;
    logic              program_running;
    logic [3:0]        index;
    logic [TimeW-1:0]  value;
    logic [7:0]        key_code;
    logic [AddrW-1:0]  address;
  } req_beat_t;

  typedef struct packed {
    logic              fired;
    kind_t             source_kind;
    logic [3:0]        source_index;
    logic [AddrW-1:0]  address_out;
    logic              flag_out;
    logic              in_interrupt;
    err_t              error;
  } rsp_beat_t;

endpackage

// ===== tb/pid_checker.sv =====
// watches both dispatcher channels, predicts every response and compares it
// depends on pid_pkg and pid_tb_pkg
`timescale 1ns / 1ps
module pid_checker
  import pid_pkg::*;
  import pid_tb_pkg::*;
#(
  parameter int NT = 4,
  parameter int NP = 10
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_ready,
  input  req_beat_t req_data,
  input  logic      rsp_valid,
  input  logic      rsp_ready,
  input  rsp_beat_t rsp_data,
  output int        fail_count,
  output int        pending
);

  rsp_beat_t expected_rsp[$];

  logic             active, paused, anyk_on, key_on, key_pend;
  logic [31:0]      resume_pc, anyk_vec, key_vec;
  logic [7:0]       key_match;
  logic [NT-1:0]    tick_on;
  logic [62:0]      tick_due [NT];
  logic [62:0]      tick_per [NT];
  logic [31:0]      tick_vec [NT];
  logic [NP-1:0]    port_on;
  logic [62:0]      port_thr [NP];
  logic [31:0]      port_vec [NP];
  logic [62:0]      port_lvl [NP];

  function automatic logic [62:0] add_clamp(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? {63{1'b1}} : s[62:0];
  endfunction

  task automatic clear_sources();
    active = 0; paused = 0; resume_pc = 0;
    anyk_on = 0; anyk_vec = 0;
    key_on = 0; key_match = 0; key_vec = 0; key_pend = 0;
    tick_on = '0; port_on = '0;
    for (int i = 0; i < NT; i++) begin
      tick_due[i] = 0; tick_per[i] = 0; tick_vec[i] = 0;
    end
    for (int i = 0; i < NP; i++) begin
      port_thr[i] = 0; port_vec[i] = 0;
    end
  endtask

  task automatic dispatch_step(input req_beat_t q, output rsp_beat_t r);
    logic tok, pok;
    int t, p;
    r = '0;
    tok = q.index < NT;
    pok = q.index >= 1 && q.index <= NP;
    t = tok ? int'(q.index) : 0;
    p = pok ? int'(q.index) - 1 : 0;
    case (q.command)
      CMD_CHECK: begin
        if ((anyk_on || key_on || |tick_on || |port_on) && !active && q.program_running) begin
          if (anyk_on && q.key_available) begin
            r.source_kind = KIND_ANY; r.address_out = anyk_vec;
          end else if (key_on && key_pend) begin
            key_pend = 0;
            r.source_kind = KIND_KEY; r.address_out = key_vec;
          end else begin
            for (int i = 0; i < NT; i++)
              if (r.source_kind == KIND_NONE && tick_on[i] && q.now_time >= tick_due[i]) begin
                tick_due[i] = add_clamp(tick_due[i], tick_per[i]);
                r.source_kind = KIND_TICK; r.source_index = 4'(i);
                r.address_out = tick_vec[i];
              end
            for (int i = 0; i < NP; i++)
              if (r.source_kind == KIND_NONE && port_on[i] && port_lvl[i] >= port_thr[i]) begin
                r.source_kind = KIND_PORT; r.source_index = 4'(i + 1);
                r.address_out = port_vec[i];
              end
          end
          if (r.source_kind != KIND_NONE) begin
            r.fired = 1; active = 1; resume_pc = q.address;
          end
        end
      end
      CMD_KEYPRESS: begin
        if (key_on && q.key_code == key_match) begin
          key_pend = 1; r.flag_out = 1;
        end
      end
      CMD_RETURN: begin
        if (!active) r.error = ERR_NOINT;
        else begin
          r.address_out = resume_pc; active = 0;
        end
      end
      CMD_ARM_TICK: begin
        if (!tok) r.error = ERR_BADIDX;
        else begin
          tick_on[t] = 1; tick_due[t] = add_clamp(q.now_time, q.value);
          tick_per[t] = q.value; tick_vec[t] = q.address;
        end
      end
      CMD_DIS_TICK: begin
        if (!tok) r.error = ERR_BADIDX;
        else begin
          tick_on[t] = 0; tick_due[t] = 0; tick_per[t] = 0; tick_vec[t] = 0;
        end
      end
      CMD_ARM_PORT: begin
        if (!pok || port_on[p]) r.error = ERR_BADIDX;
        else begin
          port_on[p] = 1; port_thr[p] = q.value; port_vec[p] = q.address;
        end
      end
      CMD_DIS_PORT: begin
        if (!pok) r.error = ERR_BADIDX;
        else begin
          port_on[p] = 0; port_thr[p] = 0; port_vec[p] = 0;
        end
      end
      CMD_ARM_ANY: begin
        anyk_on = 1; anyk_vec = q.address;
      end
      CMD_DIS_ANY: begin
        anyk_on = 0; anyk_vec = 0;
      end
      CMD_ARM_KEY: begin
        key_on = 1; key_match = q.key_code; key_vec = q.address;
      end
      CMD_DIS_KEY: begin
        key_on = 0; key_vec = 0;
      end
      CMD_PAUSE: begin
        active = 1; paused = 1; resume_pc = q.address;
      end
      CMD_RESUMEQ: begin
        r.flag_out = paused; paused = 0;
      end
      CMD_RXLEVEL: begin
        if (!pok) r.error = ERR_BADIDX;
        else port_lvl[p] = q.value;
      end
      CMD_CLEAR: clear_sources();
      default: ;
    endcase
    r.in_interrupt = active;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    rsp_beat_t r, e;
    if (rst) begin
      clear_sources();
      for (int i = 0; i < NP; i++) port_lvl[i] = 0;
      expected_rsp.delete();
    end else begin
      if (req_valid && req_ready) begin
        dispatch_step(req_data, r);
        expected_rsp.push_back(r);
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected response beat, got %0h", $time, rsp_data);
          fail_count++;
        end else begin
          e = expected_rsp.pop_front();
          cmp_field("fired", e.fired, rsp_data.fired);
          cmp_field("source_kind", e.source_kind, rsp_data.source_kind);
          cmp_field("source_index", e.source_index, rsp_data.source_index);
          cmp_field("address_out", e.address_out, rsp_data.address_out);
          cmp_field("flag_out", e.flag_out, rsp_data.flag_out);
          cmp_field("in_interrupt", e.in_interrupt, rsp_data.in_interrupt);
          cmp_field("error", e.error, rsp_data.error);
        end
      end
    end
    pending = expected_rsp.size();
  end

endmodule

// ===== tb/prioritized_interrupt_dispatcher_tb.sv =====
// stimulus and verdict for the interrupt dispatcher
// depends on pid_pkg, pid_tb_pkg, pid_if, pid_checker and the dispatcher
`timescale 1ns / 1ps
module prioritized_interrupt_dispatcher_tb;
  import pid_pkg::*;
  import pid_tb_pkg::*;

  localparam int CycleLimit = 500000;

  logic clk = 0;
  logic rst = 1;
  logic calm = 0;
  int   cycles = 0;
  int   fail_count, pending;
  logic [62:0] sim_ns = 0;
  logic [7:0]  armed_code = 0;

  pid_if #(.payload_t(req_beat_t)) in_ch();
  pid_if #(.payload_t(rsp_beat_t)) out_ch();

  prioritized_interrupt_dispatcher uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  pid_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(in_ch.valid), .req_ready(in_ch.ready), .req_data(in_ch.data),
    .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready), .rsp_data(out_ch.data),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) out_ch.ready <= calm || $urandom_range(99) >= 18;

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  function automatic req_beat_t mk(cmd_t c, logic [62:0] now, logic kav, logic run,
                                   logic [3:0] idx, logic [62:0] val, logic [7:0] kc,
                                   logic [31:0] addr);
    req_beat_t b;
    b.command = c; b.now_time = now; b.key_available = kav; b.program_running = run;
    b.index = idx; b.value = val; b.key_code = kc; b.address = addr;
    return b;
  endfunction

  task automatic send(input req_beat_t b);
    while (!calm && $urandom_range(99) < 18) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data  <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic req_beat_t random_req();
    req_beat_t b;
    int sel;
    sel = $urandom_range(99);
    b = mk(CMD_CHECK, sim_ns, $urandom_range(99) < 30, $urandom_range(99) < 90,
           4'($urandom_range(0, 11)), 63'($urandom_range(0, 40)),
           8'($urandom_range(0, 255)), $urandom);
    if ($urandom_range(99) < 4) b.index = 4'($urandom_range(0, 15));
    if ($urandom_range(99) < 5) b.value = rand63();
    if ($urandom_range(99) < 4) b.now_time = rand63();
    if ($urandom_range(99) < 50) b.key_code = armed_code;
    if (sel < 35)      b.command = CMD_CHECK;
    else if (sel < 47) b.command = CMD_RETURN;
    else if (sel < 53) b.command = CMD_KEYPRESS;
    else if (sel < 99) b.command = cmd_t'($urandom_range(3, 14));
    else               b.command = CMD_NOP;
    if (b.command == CMD_CLEAR && $urandom_range(3) != 0) b.command = CMD_RESUMEQ;
    if (b.command == CMD_ARM_KEY) armed_code = b.key_code;
    return b;
  endfunction

  initial begin
    req_beat_t dir[$];
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    dir.push_back(mk(CMD_ARM_ANY, 0, 0, 1, 0, 0, 0, 32'hFFFF_FFFF));
    dir.push_back(mk(CMD_CHECK, 0, 1, 1, 0, 0, 0, 32'h1234));
    dir.push_back(mk(CMD_RETURN, 0, 0, 1, 0, 0, 0, 0));
    dir.push_back(mk(CMD_RETURN, 0, 0, 1, 0, 0, 0, 0));
    dir.push_back(mk(CMD_DIS_ANY, 0, 0, 1, 0, 0, 0, 0));
    dir.push_back(mk(CMD_ARM_KEY, 0, 0, 1, 0, 0, 8'hFF, 32'hA5A5_0001));
    dir.push_back(mk(CMD_KEYPRESS, 0, 0, 1, 0, 0, 8'h00, 0));
    dir.push_back(mk(CMD_KEYPRESS, 0, 0, 1, 0, 0, 8'hFF, 0));
    dir.push_back(mk(CMD_DIS_KEY, 0, 0, 1, 0, 0, 0, 0));
    dir.push_back(mk(CMD_ARM_KEY, 0, 0, 1, 0, 0, 8'h00, 32'h5A5A));
    dir.push_back(mk(CMD_CHECK, 0, 0, 1, 0, 0, 0, 32'h77));
    dir.push_back(mk(CMD_RETURN, 0, 0, 1, 0, 0, 0, 0));
    dir.push_back(mk(CMD_ARM_TICK, 0, 0, 1, 0, 0, 0, 32'h100));
    dir.push_back(mk(CMD_ARM_TICK, {63{1'b1}}, 0, 1, 3, {63{1'b1}}, 0, 32'h300));
    dir.push_back(mk(CMD_ARM_TICK, 0, 0, 1, 4, 5, 0, 0));
    dir.push_back(mk(CMD_ARM_PORT, 0, 0, 1, 0, 0, 0, 0));
    dir.push_back(mk(CMD_ARM_PORT, 0, 0, 1, 10, 0, 0, 32'hA00));
    dir.push_back(mk(CMD_ARM_PORT, 0, 0, 1, 10, 3, 0, 32'hA01));
    dir.push_back(mk(CMD_RXLEVEL, 0, 0, 1, 11, 4, 0, 0));
    dir.push_back(mk(CMD_RXLEVEL, 0, 0, 1, 10, {63{1'b1}}, 0, 0));
    dir.push_back(mk(CMD_CHECK, {63{1'b1}}, 1, 0, 0, 0, 0, 32'h9));
    dir.push_back(mk(CMD_CHECK, {63{1'b1}}, 0, 1, 0, 0, 0, 32'h9));
    dir.push_back(mk(CMD_PAUSE, 0, 0, 1, 0, 0, 0, 32'hBEEF));
    dir.push_back(mk(CMD_CHECK, 0, 0, 1, 0, 0, 0, 0));
    dir.push_back(mk(CMD_RESUMEQ, 0, 0, 1, 0, 0, 0, 0));
    dir.push_back(mk(CMD_RETURN, 0, 0, 1, 0, 0, 0, 0));
    dir.push_back(mk(CMD_NOP, 0, 0, 1, 4'hF, 0, 0, 0));
    dir.push_back(mk(CMD_DIS_TICK, 0, 0, 1, 0, 0, 0, 0));
    dir.push_back(mk(CMD_DIS_PORT, 0, 0, 1, 10, 0, 0, 0));
    dir.push_back(mk(CMD_CLEAR, 0, 0, 1, 0, 0, 0, 0));
    foreach (dir[i]) send(dir[i]);

    for (int n = 0; n < 1200; n++) begin
      calm = (n >= 300 && n < 450);
      if (n == 700) begin
        in_ch.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      sim_ns = sim_ns + 63'($urandom_range(0, 12));
      send(random_req());
    end
    in_ch.valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pid_pkg.sv
rtl/pid_if.sv
rtl/pid_ctrl.sv
rtl/pid_dp.sv
rtl/prioritized_interrupt_dispatcher.sv
tb/pid_tb_pkg.sv
tb/pid_checker.sv
tb/prioritized_interrupt_dispatcher_tb.sv
